FILE: hdl/skm_pkg.sv
// Shared constants, types and helper functions of the survival split scorer.
package skm_pkg;

  localparam int MAX_OBS   = 1024;
  localparam int OBS_AW    = $clog2(MAX_OBS);
  localparam int CNT_W     = $clog2(MAX_OBS + 1);
  localparam int TIME_BITS = 16;
  localparam int WORD_W    = TIME_BITS + 3;
  localparam int AREA_W    = 48;
  localparam int SURV_W    = 31;
  localparam int CFG_MIN_W = 11;
  localparam int RATIO_W   = 17;
  localparam int DIV_DW    = 64;
  localparam int DIV_VW    = 36;
  localparam int SQ_XW     = 52;
  localparam int SQ_RW     = SQ_XW / 2;
  localparam int NL_W      = 34;
  localparam int PADDR_W   = 5;

  localparam logic [SURV_W-1:0] Q30_ONE = SURV_W'(1) << 30;
  localparam logic [29:0]       LN2_Q30 = 30'd744261118;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  localparam logic [2:0] REG_TAIL_MODE = 3'd0;
  localparam logic [2:0] REG_MIN_SIDE  = 3'd1;
  localparam logic [2:0] REG_MIN_CTRL  = 3'd2;
  localparam logic [2:0] REG_MIN_TRT   = 3'd3;
  localparam logic [2:0] REG_RATIO_LO  = 3'd4;
  localparam logic [2:0] REG_RATIO_HI  = 3'd5;

  typedef struct packed {
    logic                 tail_mode;
    logic [CFG_MIN_W-1:0] min_side;
    logic [CFG_MIN_W-1:0] min_ctrl;
    logic [CFG_MIN_W-1:0] min_trt;
    logic [RATIO_W-1:0]   ratio_low;
    logic [RATIO_W-1:0]   ratio_high;
  } cfg_t;

  typedef logic [7:0][CNT_W-1:0] counts_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [29:0] surv;
  } log_req_t;

  typedef struct packed {
    logic            done;
    logic [NL_W-1:0] neg_ln;
  } log_rsp_t;

  typedef struct packed {
    logic             start;
    logic [SQ_XW-1:0] x;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [SQ_RW-1:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_sts_t;

  typedef struct packed {
    logic        split_valid;
    logic [63:0] split_score;
  } result_t;

  function automatic logic [AREA_W-1:0] area_add(input logic [AREA_W-1:0] a,
                                                 input logic [63:0] b);
    logic [64:0] sum;
    begin
      sum = 65'(a) + 65'(b);
      area_add = (sum > 65'(AREA_MAX)) ? AREA_MAX : sum[AREA_W-1:0];
    end
  endfunction

endpackage

FILE: hdl/skm_if.sv
// Request channels for observations and split results.
interface skm_obs_if;
  logic                           valid;
  logic                           ready;
  logic [skm_pkg::TIME_BITS-1:0]  obs_time;
  logic                           event_flag;
  logic                           is_treatment;
  logic                           goes_left;
  logic                           last_obs;

  modport source (output valid, obs_time, event_flag, is_treatment, goes_left, last_obs,
                  input ready);
  modport sink (input valid, obs_time, event_flag, is_treatment, goes_left, last_obs,
                output ready);
endinterface

interface skm_res_if;
  logic        valid;
  logic        ready;
  logic        split_valid;
  logic [63:0] split_score;

  modport source (output valid, split_valid, split_score, input ready);
  modport sink (input valid, split_valid, split_score, output ready);
endinterface

FILE: hdl/skm_div.sv
// Restoring divider that produces one quotient bit per cycle.
module skm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skm_pkg::div_req_t req_i,
  output skm_pkg::div_rsp_t rsp_o
);
  import skm_pkg::*;

  logic [DIV_DW-1:0]         dvd_q;
  logic [DIV_VW-1:0]         dv_q;
  logic [DIV_VW-1:0]         rem_q;
  logic [$clog2(DIV_DW)-1:0] cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [DIV_VW:0]           rem_sh;
  logic                      ge;

  assign rem_sh = {rem_q, dvd_q[DIV_DW-1]};
  assign ge     = rem_sh >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        dvd_q  <= req_i.dividend;
        dv_q   <= req_i.divisor;
        rem_q  <= '0;
        cnt_q  <= '1;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (ge) begin
          rem_q <= DIV_VW'(rem_sh - {1'b0, dv_q});
        end else begin
          rem_q <= rem_sh[DIV_VW-1:0];
        end
        dvd_q <= {dvd_q[DIV_DW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;
endmodule

FILE: hdl/skm_log.sv
// Negative natural logarithm of a Q0.30 survival value by repeated squaring.
module skm_log (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skm_pkg::log_req_t req_i,
  output skm_pkg::log_rsp_t rsp_o
);
  import skm_pkg::*;

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_RED, L_MUL, L_OUT} lstate_e;

  lstate_e         state_q;
  logic [31:0]     m_q;
  logic [4:0]      e_q;
  logic [29:0]     f_q;
  logic [4:0]      b_q;
  logic [61:0]     sq_q;
  logic [63:0]     prod_q;
  logic [NL_W-1:0] nl_q;
  logic            done_q;
  logic [31:0]     mm;
  logic [34:0]     ef;
  logic [NL_W-1:0] nl_raw;

  assign mm     = sq_q[61:30];
  assign ef     = {e_q, 30'b0} - 35'(f_q);
  assign nl_raw = prod_q[63:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            m_q     <= {2'b0, req_i.surv};
            e_q     <= '0;
            f_q     <= '0;
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (m_q < 32'(Q30_ONE)) begin
            m_q <= {m_q[30:0], 1'b0};
            e_q <= e_q + 1'b1;
          end else begin
            b_q     <= 5'd29;
            state_q <= L_SQ;
          end
        end
        L_SQ: begin
          sq_q    <= m_q[30:0] * m_q[30:0];
          state_q <= L_RED;
        end
        L_RED: begin
          if (mm[31]) begin
            m_q      <= {1'b0, mm[31:1]};
            f_q[b_q] <= 1'b1;
          end else begin
            m_q <= mm;
          end
          if (b_q == '0) begin
            state_q <= L_MUL;
          end else begin
            b_q     <= b_q - 1'b1;
            state_q <= L_SQ;
          end
        end
        L_MUL: begin
          prod_q  <= 64'(ef * LN2_Q30);
          state_q <= L_OUT;
        end
        L_OUT: begin
          nl_q    <= (nl_raw == '0) ? NL_W'(1) : nl_raw;
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.neg_ln = nl_q;
endmodule

FILE: hdl/skm_sqrt.sv
// Bitwise integer square root, one result bit per cycle.
module skm_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  skm_pkg::sqrt_req_t req_i,
  output skm_pkg::sqrt_rsp_t rsp_o
);
  import skm_pkg::*;

  logic [SQ_XW-1:0] x_q;
  logic [SQ_XW-1:0] r_q;
  logic [SQ_XW-1:0] bit_q;
  logic             busy_q;
  logic             done_q;
  logic [SQ_XW-1:0] trial;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        x_q    <= req_i.x;
        r_q    <= '0;
        bit_q  <= SQ_XW'(1) << (SQ_XW - 2);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (x_q >= trial) begin
          x_q <= x_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = r_q[SQ_RW-1:0];
endmodule

FILE: hdl/skm_core.sv
// Compute sequencer: constraint check, curve walks over the store, tail and final score.
module skm_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  skm_pkg::cfg_t                   cfg_i,
  input  skm_pkg::counts_t                counts_i,
  input  logic [skm_pkg::CNT_W-1:0]       obs_cnt_i,
  output logic [skm_pkg::OBS_AW-1:0]      rd_addr_o,
  input  logic [skm_pkg::WORD_W-1:0]      rd_data_i,
  input  logic                            out_free_i,
  output skm_pkg::core_sts_t              sts_o,
  output skm_pkg::result_t                res_o
);
  import skm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_CINIT, S_RD, S_EX, S_CL1, S_CL2, S_CLDIV, S_CLEND,
    S_TAIL0, S_TAILLOG, S_TAILMUL, S_TAILST, S_TAILDIV, S_NEXT, S_DIFF,
    S_SQRT, S_MUL, S_SUM, S_DONE
  } cstate_e;

  cstate_e             state_q;
  logic [1:0]          cur_q;
  logic [CNT_W-1:0]    idx_q;
  logic [CNT_W-1:0]    n_q;
  logic [SURV_W-1:0]   s_q;
  logic [TIME_BITS-1:0] prev_q;
  logic [AREA_W-1:0]   area_q;
  logic [3:0][AREA_W-1:0] areas_q;
  logic                open_q;
  logic [TIME_BITS-1:0] gt_q;
  logic [CNT_W-1:0]    gsz_q;
  logic [CNT_W-1:0]    gev_q;
  logic                pend_q;
  logic [TIME_BITS-1:0] pt_q;
  logic                pev_q;
  logic                skip_q;
  logic [SURV_W+TIME_BITS-1:0] p1_q;
  logic [SURV_W+CNT_W-1:0]     p2_q;
  logic [SURV_W+TIME_BITS-1:0] p3_q;
  logic [NL_W-1:0]     nl_q;
  logic [2*CNT_W-1:0]  nprod_q;
  logic [49:0]         ad_q;
  logic [SQ_RW-1:0]    sq_q;
  logic [SQ_RW+31:0]   pa_q;
  logic [SQ_RW+17:0]   pb_q;
  result_t             res_q;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  log_req_t  log_req;
  log_rsp_t  log_rsp;
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  logic [TIME_BITS-1:0] w_time;
  logic                 w_ev;
  logic                 member;
  logic                 last_w;
  logic [CNT_W-1:0]     nl_w;
  logic [CNT_W-1:0]     nr_w;
  logic                 ok_w;
  logic [CNT_W-1:0]     d_w;
  logic [TIME_BITS-1:0] dt_w;
  logic                 tail_w;
  logic signed [50:0]   dd_w;
  logic [79:0]          sum_w;

  function automatic logic ratio_ok(input logic [CNT_W-1:0] nt, input logic [CNT_W-1:0] n,
                                    input logic [RATIO_W-1:0] lo,
                                    input logic [RATIO_W-1:0] hi);
    logic [RATIO_W+CNT_W-1:0] a;
    logic [RATIO_W+CNT_W-1:0] bl;
    logic [RATIO_W+CNT_W-1:0] bh;
    begin
      a  = (RATIO_W+CNT_W)'({nt, 16'b0});
      bl = lo * n;
      bh = hi * n;
      ratio_ok = (n == '0) || ((a >= bl) && (a <= bh));
    end
  endfunction

  assign w_time = rd_data_i[TIME_BITS-1:0];
  assign w_ev   = rd_data_i[TIME_BITS];
  assign member = (rd_data_i[TIME_BITS+2] == cur_q[1]) && (rd_data_i[TIME_BITS+1] == cur_q[0]);
  assign last_w = (CNT_W'(idx_q + 1'b1) == obs_cnt_i);
  assign nl_w   = counts_i[2] + counts_i[3];
  assign nr_w   = counts_i[0] + counts_i[1];
  assign ok_w   = (nl_w >= cfg_i.min_side) && (nr_w >= cfg_i.min_side) &&
                  (counts_i[3] >= cfg_i.min_trt) && (counts_i[1] >= cfg_i.min_trt) &&
                  (counts_i[2] >= cfg_i.min_ctrl) && (counts_i[0] >= cfg_i.min_ctrl) &&
                  ratio_ok(counts_i[3], nl_w, cfg_i.ratio_low, cfg_i.ratio_high) &&
                  ratio_ok(counts_i[1], nr_w, cfg_i.ratio_low, cfg_i.ratio_high) &&
                  (counts_i[4] != '0) && (counts_i[5] != '0) &&
                  (counts_i[6] != '0) && (counts_i[7] != '0);
  assign d_w    = (gev_q > n_q) ? n_q : gev_q;
  assign dt_w   = (gt_q > prev_q) ? TIME_BITS'(gt_q - prev_q) : '0;
  assign tail_w = cfg_i.tail_mode && (s_q != '0) && (s_q < Q30_ONE);
  assign dd_w   = ($signed({3'b0, areas_q[3]}) - $signed({3'b0, areas_q[2]})) -
                  ($signed({3'b0, areas_q[1]}) - $signed({3'b0, areas_q[0]}));
  assign sum_w  = {4'b0, pb_q, 32'b0} + 80'(pa_q);

  assign div_req.start    = ((state_q == S_CL2) && !skip_q) || (state_q == S_TAILST);
  assign div_req.dividend = (state_q == S_TAILST) ? {1'b0, p3_q, 16'b0} : DIV_DW'(p2_q);
  assign div_req.divisor  = (state_q == S_TAILST) ? DIV_VW'(nl_q) : DIV_VW'(n_q);
  assign log_req.start    = (state_q == S_TAIL0) && tail_w;
  assign log_req.surv     = s_q[29:0];
  assign sq_req.start     = (state_q == S_DIFF);
  assign sq_req.x         = SQ_XW'({nprod_q, 32'b0});

  skm_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  skm_log u_log (.clk_i, .rst_ni, .req_i(log_req), .rsp_o(log_rsp));
  skm_sqrt u_sqrt (.clk_i, .rst_ni, .req_i(sq_req), .rsp_o(sq_rsp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q   <= '0;
      idx_q   <= '0;
      open_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          nprod_q <= nl_w * nr_w;
          cur_q   <= '0;
          if (ok_w) begin
            state_q <= S_CINIT;
          end else begin
            res_q   <= '0;
            state_q <= S_DONE;
          end
        end
        S_CINIT: begin
          n_q     <= counts_i[cur_q];
          s_q     <= Q30_ONE;
          prev_q  <= '0;
          area_q  <= '0;
          open_q  <= 1'b0;
          pend_q  <= 1'b0;
          idx_q   <= '0;
          state_q <= (obs_cnt_i == '0) ? S_TAIL0 : S_RD;
        end
        S_RD: state_q <= S_EX;
        S_EX: begin
          if (member && open_q && (w_time != gt_q)) begin
            pend_q  <= 1'b1;
            pt_q    <= w_time;
            pev_q   <= w_ev;
            state_q <= S_CL1;
          end else begin
            if (member) begin
              if (open_q) begin
                gsz_q <= gsz_q + 1'b1;
                gev_q <= gev_q + CNT_W'(w_ev);
              end else begin
                open_q <= 1'b1;
                gt_q   <= w_time;
                gsz_q  <= CNT_W'(1);
                gev_q  <= CNT_W'(w_ev);
              end
            end
            if (!last_w) begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_RD;
            end else if (member || open_q) begin
              state_q <= S_CL1;
            end else begin
              state_q <= S_TAIL0;
            end
          end
        end
        S_CL1: begin
          p1_q    <= s_q * dt_w;
          p2_q    <= s_q * CNT_W'(n_q - d_w);
          skip_q  <= (n_q == '0) || (d_w == '0);
          state_q <= S_CL2;
        end
        S_CL2: begin
          area_q  <= area_add(area_q, 64'(p1_q >> 14));
          state_q <= skip_q ? S_CLEND : S_CLDIV;
        end
        S_CLDIV: begin
          if (div_rsp.done) begin
            s_q     <= div_rsp.quotient[SURV_W-1:0];
            state_q <= S_CLEND;
          end
        end
        S_CLEND: begin
          n_q    <= (gsz_q > n_q) ? '0 : CNT_W'(n_q - gsz_q);
          prev_q <= gt_q;
          if (pend_q) begin
            pend_q <= 1'b0;
            gt_q   <= pt_q;
            gsz_q  <= CNT_W'(1);
            gev_q  <= CNT_W'(pev_q);
            if (last_w) begin
              state_q <= S_CL1;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_RD;
            end
          end else begin
            state_q <= S_TAIL0;
          end
        end
        S_TAIL0: state_q <= tail_w ? S_TAILLOG : S_NEXT;
        S_TAILLOG: begin
          if (log_rsp.done) begin
            nl_q    <= log_rsp.neg_ln;
            state_q <= S_TAILMUL;
          end
        end
        S_TAILMUL: begin
          p3_q    <= prev_q * s_q;
          state_q <= S_TAILST;
        end
        S_TAILST: state_q <= S_TAILDIV;
        S_TAILDIV: begin
          if (div_rsp.done) begin
            area_q  <= area_add(area_q, div_rsp.quotient);
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          areas_q[cur_q] <= area_q;
          if (cur_q == 2'd3) begin
            state_q <= S_DIFF;
          end else begin
            cur_q   <= cur_q + 1'b1;
            state_q <= S_CINIT;
          end
        end
        S_DIFF: begin
          ad_q    <= dd_w[50] ? 50'(-dd_w) : 50'(dd_w);
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_rsp.done) begin
            sq_q    <= sq_rsp.root;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          pa_q    <= sq_q * ad_q[31:0];
          pb_q    <= sq_q * ad_q[49:32];
          state_q <= S_SUM;
        end
        S_SUM: begin
          res_q.split_valid <= 1'b1;
          res_q.split_score <= sum_w[79:16];
          state_q           <= S_DONE;
        end
        S_DONE: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rd_addr_o  = idx_q[OBS_AW-1:0];
  assign sts_o.idle = (state_q == S_IDLE);
  assign sts_o.done = (state_q == S_DONE) && out_free_i;
  assign res_o      = res_q;
endmodule

FILE: hdl/survival_split_km_score.sv
// Kaplan-Meier split scorer: observations load one per cycle into a 1024-entry store; the
// request marked last starts the computation, during which no observation is taken. The
// computation walks the store once per side and group curve, closing each tie group with a
// multiply and, when the group holds an event, a 64-step divide; each curve adds a tail term
// when it is on (normalize, 30 squarings, one divide), and a square root and final product
// end the computation. A rejected split skips the curve walks and goes straight to the
// result. The result waits in an output register while the next node loads.
module survival_split_km_score (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  skm_obs_if.sink                       obs_i,
  skm_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skm_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import skm_pkg::*;

  cfg_t              cfg_q;
  logic [CNT_W-1:0]  obs_cnt_q;
  counts_t           counts_q;
  logic [WORD_W-1:0] obs_mem_q [MAX_OBS];
  logic [WORD_W-1:0] rd_data_q;
  logic [OBS_AW-1:0] rd_addr;
  logic              out_valid_q;
  result_t           out_q;
  result_t           core_res;
  core_sts_t         core_sts;
  logic              accept;
  logic              start;
  logic              out_free;
  logic              store_ok;
  logic [1:0]        grp_sel;
  logic [2:0]        reg_idx;
  logic              cfg_wr;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:2];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign obs_i.ready = core_sts.idle;
  assign accept   = obs_i.valid && obs_i.ready;
  assign start    = accept && obs_i.last_obs;
  assign store_ok = obs_cnt_q < CNT_W'(MAX_OBS);
  assign grp_sel  = {obs_i.goes_left, obs_i.is_treatment};
  assign out_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tail_mode  <= 1'b0;
      cfg_q.min_side   <= CFG_MIN_W'(1);
      cfg_q.min_ctrl   <= CFG_MIN_W'(1);
      cfg_q.min_trt    <= CFG_MIN_W'(1);
      cfg_q.ratio_low  <= '0;
      cfg_q.ratio_high <= RATIO_W'(65536);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TAIL_MODE: cfg_q.tail_mode  <= pwdata[0];
        REG_MIN_SIDE:  cfg_q.min_side   <= pwdata[CFG_MIN_W-1:0];
        REG_MIN_CTRL:  cfg_q.min_ctrl   <= pwdata[CFG_MIN_W-1:0];
        REG_MIN_TRT:   cfg_q.min_trt    <= pwdata[CFG_MIN_W-1:0];
        REG_RATIO_LO:  cfg_q.ratio_low  <= pwdata[RATIO_W-1:0];
        REG_RATIO_HI:  cfg_q.ratio_high <= pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TAIL_MODE: prdata = 32'(cfg_q.tail_mode);
      REG_MIN_SIDE:  prdata = 32'(cfg_q.min_side);
      REG_MIN_CTRL:  prdata = 32'(cfg_q.min_ctrl);
      REG_MIN_TRT:   prdata = 32'(cfg_q.min_trt);
      REG_RATIO_LO:  prdata = 32'(cfg_q.ratio_low);
      REG_RATIO_HI:  prdata = 32'(cfg_q.ratio_high);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_cnt_q <= '0;
      counts_q  <= '0;
    end else if (core_sts.done) begin
      obs_cnt_q <= '0;
      counts_q  <= '0;
    end else if (accept && store_ok) begin
      obs_cnt_q         <= obs_cnt_q + 1'b1;
      counts_q[grp_sel] <= counts_q[grp_sel] + 1'b1;
      if (obs_i.event_flag) begin
        counts_q[{1'b1, grp_sel}] <= counts_q[{1'b1, grp_sel}] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && store_ok) begin
      obs_mem_q[obs_cnt_q[OBS_AW-1:0]] <= {obs_i.goes_left, obs_i.is_treatment,
                                           obs_i.event_flag, obs_i.obs_time};
    end
    rd_data_q <= obs_mem_q[rd_addr];
  end

  skm_core u_core (
    .clk_i,
    .rst_ni,
    .start_i    (start),
    .cfg_i      (cfg_q),
    .counts_i   (counts_q),
    .obs_cnt_i  (obs_cnt_q),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data_q),
    .out_free_i (out_free),
    .sts_o      (core_sts),
    .res_o      (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_sts.done) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_sts.done) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.split_valid = out_q.split_valid;
  assign res_o.split_score = out_q.split_score;
endmodule

FILE: tb/sv/tb_survival_split_km_score.sv
// Testbench of the Kaplan-Meier split scorer: random and directed nodes checked against a predictor.
`timescale 1ns / 100ps

module tb_survival_split_km_score;
  import skm_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int DRAIN_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  skm_obs_if obs ();
  skm_res_if res ();

  survival_split_km_score u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .obs_i   (obs),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Shadow configuration and node state of the scorer.
  cfg_t                cfg_q;
  logic [WORD_W-1:0]   node_mem [MAX_OBS];
  int unsigned         node_cnt;
  int unsigned         cell_cnt [8];
  result_t             score_q [$];
  int                  err_cnt = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  function automatic longint unsigned sat_area_add(longint unsigned a, longint unsigned b);
    longint unsigned amax;
    amax = (64'd1 << 48) - 1;
    return (b > amax - a) ? amax : a + b;
  endfunction

  function automatic longint unsigned neg_ln_q30(longint unsigned s);
    longint unsigned m, e, f, nl;
    m = s;
    e = 0;
    f = 0;
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      e++;
    end
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f |= 64'd1 << b;
      end
    end
    nl = (((e << 30) - f) * 64'd744261118) >> 30;
    return (nl == 0) ? 64'd1 : nl;
  endfunction

  function automatic longint unsigned curve_area(int c);
    longint unsigned surv, area, prev, t, gt, dt, nl, p, q, r, tail;
    int unsigned     risk, gsz, gev, d;
    logic            open;
    logic [WORD_W-1:0] w;
    risk = cell_cnt[c];
    surv = 64'd1 << 30;
    prev = 0;
    area = 0;
    gt = 0;
    gsz = 0;
    gev = 0;
    open = 1'b0;
    for (int unsigned i = 0; i <= node_cnt; i++) begin
      if (i < node_cnt) begin
        w = node_mem[i];
        t = w[TIME_BITS-1:0];
        if (w[TIME_BITS+2] != c[1] || w[TIME_BITS+1] != c[0]) continue;
      end
      if (open && (i == node_cnt || t != gt)) begin
        dt = (gt > prev) ? gt - prev : 0;
        area = sat_area_add(area, (surv * dt) >> 14);
        if (risk > 0) begin
          d = (gev > risk) ? risk : gev;
          surv = surv * (risk - d) / risk;
        end
        risk = (gsz > risk) ? 0 : risk - gsz;
        prev = gt;
        open = 1'b0;
      end
      if (i == node_cnt) break;
      if (!open) begin
        open = 1'b1;
        gt = t;
        gsz = 0;
        gev = 0;
      end
      gsz++;
      gev += w[TIME_BITS];
    end
    if (cfg_q.tail_mode && surv != 0 && surv < (64'd1 << 30)) begin
      nl = neg_ln_q30(surv);
      p = prev * surv;
      q = p / nl;
      r = p % nl;
      tail = (q >= (64'd1 << 48)) ? (64'd1 << 48) - 1 : (q << 16) + (r << 16) / nl;
      area = sat_area_add(area, tail);
    end
    return area;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic ratio_fits(longint unsigned nt, longint unsigned n);
    if (n == 0) return 1'b1;
    if (nt * 65536 < longint'(cfg_q.ratio_low) * n) return 1'b0;
    if (nt * 65536 > longint'(cfg_q.ratio_high) * n) return 1'b0;
    return 1'b1;
  endfunction

  function automatic longint unsigned mul_q16_sat(longint unsigned a, longint unsigned b);
    longint unsigned plo, phi, t, u;
    plo = a * (b & 64'hFFFF_FFFF);
    phi = a * (b >> 32);
    if (phi >= (64'd1 << 48)) return '1;
    t = phi << 16;
    u = plo >> 16;
    if (u > ~t) return '1;
    return t + u;
  endfunction

  function automatic result_t node_score();
    result_t         rs;
    longint unsigned nrc, nrt, nlc, nlt, nl, nr, ad;
    longint unsigned area [4];
    longint          dl, dr, d;
    logic            ok;
    nrc = cell_cnt[0];
    nrt = cell_cnt[1];
    nlc = cell_cnt[2];
    nlt = cell_cnt[3];
    nl = nlc + nlt;
    nr = nrc + nrt;
    ok = nl >= cfg_q.min_side && nr >= cfg_q.min_side &&
         nlt >= cfg_q.min_trt && nrt >= cfg_q.min_trt &&
         nlc >= cfg_q.min_ctrl && nrc >= cfg_q.min_ctrl &&
         ratio_fits(nlt, nl) && ratio_fits(nrt, nr) &&
         cell_cnt[4] >= 1 && cell_cnt[5] >= 1 && cell_cnt[6] >= 1 && cell_cnt[7] >= 1;
    rs = '0;
    if (!ok) return rs;
    for (int c = 0; c < 4; c++) area[c] = curve_area(c);
    dl = longint'(area[3]) - longint'(area[2]);
    dr = longint'(area[1]) - longint'(area[0]);
    d = dl - dr;
    ad = (d < 0) ? longint'(-d) : longint'(d);
    rs.split_valid = 1'b1;
    rs.split_score = mul_q16_sat(floor_sqrt((nl * nr) << 32), ad);
    return rs;
  endfunction

  function automatic void load_obs(logic [TIME_BITS-1:0] t, logic ev, logic tr, logic lf,
                                   logic last);
    if (node_cnt < MAX_OBS) begin
      node_mem[node_cnt] = {lf, tr, ev, t};
      node_cnt++;
      cell_cnt[{lf, tr}]++;
      if (ev) cell_cnt[4 + {lf, tr}]++;
    end
    if (last) begin
      score_q.push_back(node_score());
      node_cnt = 0;
      foreach (cell_cnt[k]) cell_cnt[k] = 0;
    end
  endfunction

  task automatic send_obs(logic [TIME_BITS-1:0] t, logic ev, logic tr, logic lf, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      obs.valid <= 1'b0;
    end
    @(negedge clk_i);
    obs.valid <= 1'b1;
    obs.obs_time <= t;
    obs.event_flag <= ev;
    obs.is_treatment <= tr;
    obs.goes_left <= lf;
    obs.last_obs <= last;
    do @(posedge clk_i); while (!obs.ready);
    load_obs(t, ev, tr, lf, last);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    obs.valid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_TAIL_MODE: cfg_q.tail_mode = value[0];
      REG_MIN_SIDE:  cfg_q.min_side = value[CFG_MIN_W-1:0];
      REG_MIN_CTRL:  cfg_q.min_ctrl = value[CFG_MIN_W-1:0];
      REG_MIN_TRT:   cfg_q.min_trt = value[CFG_MIN_W-1:0];
      REG_RATIO_LO:  cfg_q.ratio_low = value[RATIO_W-1:0];
      REG_RATIO_HI:  cfg_q.ratio_high = value[RATIO_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_all(logic tail, int mside, int mctrl, int mtrt, int rlo, int rhi);
    wait_idle();
    cfg_write(REG_TAIL_MODE, 32'(tail));
    cfg_write(REG_MIN_SIDE, mside);
    cfg_write(REG_MIN_CTRL, mctrl);
    cfg_write(REG_MIN_TRT, mtrt);
    cfg_write(REG_RATIO_LO, rlo);
    cfg_write(REG_RATIO_HI, rhi);
  endtask

  // A node of n observations with nondecreasing times, apart from rare backward steps.
  task automatic send_node(int n, logic full_range);
    int t;
    t = full_range ? $urandom_range(65535) : $urandom_range(200);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) t = $urandom_range(t);
      else t = t + $urandom_range(3) * $urandom_range(40);
      if (t > 65535) t = 65535;
      send_obs(TIME_BITS'(t), $urandom_range(99) < 65, 1'($urandom_range(1)),
               1'($urandom_range(1)), i == n - 1);
    end
  endtask

  task automatic test_directed();
    // All four cells with events, ties, and both time extremes.
    send_obs(16'd0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_obs(16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
    send_obs(16'd5, 1'b1, 1'b1, 1'b0, 1'b0);
    send_obs(16'd5, 1'b1, 1'b0, 1'b1, 1'b0);
    send_obs(16'd5, 1'b0, 1'b0, 1'b1, 1'b0);
    send_obs(16'd900, 1'b1, 1'b1, 1'b1, 1'b0);
    send_obs(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1);
    // Time that steps backwards inside a curve.
    send_obs(16'd300, 1'b1, 1'b0, 1'b0, 1'b0);
    send_obs(16'd100, 1'b1, 1'b1, 1'b0, 1'b0);
    send_obs(16'd50, 1'b1, 1'b0, 1'b1, 1'b0);
    send_obs(16'd40, 1'b1, 1'b1, 1'b1, 1'b0);
    send_obs(16'd7, 1'b0, 1'b1, 1'b1, 1'b1);
    // No event in the left treatment cell: rejected.
    send_obs(16'd1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_obs(16'd2, 1'b1, 1'b1, 1'b0, 1'b0);
    send_obs(16'd3, 1'b1, 1'b0, 1'b1, 1'b0);
    send_obs(16'd4, 1'b0, 1'b1, 1'b1, 1'b1);
    // Empty right side.
    send_obs(16'd1, 1'b1, 1'b0, 1'b1, 1'b0);
    send_obs(16'd2, 1'b1, 1'b1, 1'b1, 1'b1);
    // Tail term on, with one curve falling to zero survival.
    cfg_all(1'b1, 1, 1, 1, 0, 65536);
    send_obs(16'd10, 1'b1, 1'b0, 1'b0, 1'b0);
    send_obs(16'd20, 1'b1, 1'b1, 1'b0, 1'b0);
    send_obs(16'd30, 1'b0, 1'b1, 1'b0, 1'b0);
    send_obs(16'd40, 1'b1, 1'b0, 1'b1, 1'b0);
    send_obs(16'd50, 1'b0, 1'b0, 1'b1, 1'b0);
    send_obs(16'd60, 1'b1, 1'b1, 1'b1, 1'b0);
    send_obs(16'd60000, 1'b0, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_store_full();
    cfg_all(1'b0, 1, 1, 1, 0, 65536);
    send_node(MAX_OBS + 2, 1'b0);
  endtask

  task automatic test_cfg_extremes();
    cfg_all(1'b0, 1024, 1024, 1024, 0, 65536);
    send_node(20, 1'b0);
    cfg_all(1'b1, 0, 0, 0, 0, 65536);
    send_node(16, 1'b0);
    send_node(2, 1'b0);
    cfg_all(1'b0, 1, 1, 1, 65536, 65536);
    send_node(16, 1'b0);
    cfg_all(1'b0, 1, 1, 1, 0, 0);
    send_node(16, 1'b0);
    cfg_all(1'b0, 2, 1, 1, 32768, 32768);
    send_node(8, 1'b0);
  endtask

  task automatic test_random();
    int sent;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 3)
        0: cfg_all(1'b0, 1, 1, 1, 0, 65536);
        1: cfg_all(1'b1, 1, 1, 1, 0, 65536);
        default: cfg_all(1'($urandom_range(1)), $urandom_range(4), $urandom_range(2),
                         $urandom_range(2), $urandom_range(30000),
                         $urandom_range(65536, 35000));
      endcase
      case (ph / 3)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      sent = 0;
      while (sent < 6) begin
        automatic int n = ($urandom_range(9) == 0) ? $urandom_range(60, 25)
                                                   : $urandom_range(20, 2);
        send_node(n, $urandom_range(3) == 0);
        sent += n;
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  always @(negedge clk_i) begin
    res.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (score_q.size() == 0) begin
        $error("unexpected split result: valid %0b score %0h", res.split_valid,
               res.split_score);
        err_cnt++;
      end else begin
        automatic result_t exp_r = score_q.pop_front();
        if (res.split_valid !== exp_r.split_valid) begin
          $error("split_valid: expected %0b, actual %0b", exp_r.split_valid, res.split_valid);
          err_cnt++;
        end
        if (res.split_score !== exp_r.split_score) begin
          $error("split_score: expected %0h, actual %0h", exp_r.split_score, res.split_score);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #(40_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    obs.valid = 1'b0;
    obs.obs_time = '0;
    obs.event_flag = 1'b0;
    obs.is_treatment = 1'b0;
    obs.goes_left = 1'b0;
    obs.last_obs = 1'b0;
    cfg_q = '{tail_mode: 1'b0, min_side: 1, min_ctrl: 1, min_trt: 1, ratio_low: 0,
              ratio_high: 65536};
    node_cnt = 0;
    foreach (cell_cnt[k]) cell_cnt[k] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_store_full();
    test_cfg_extremes();
    test_random();
    wait_idle();
    if (err_cnt == 0 && score_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
